// ===== src/bpt_pkg.sv =====
// shared types and constants of the barycentric point-in-triangle test
package bpt_pkg;

    localparam int OUT_W = 32;
    localparam int TOL_W = 10;

    localparam logic [OUT_W-1:0] OUT_MAX = 32'h7fff_ffff;
    localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

    // sideband that travels through the divider alongside each request
    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic degen;
    } div_tag_t;

endpackage

// ===== src/bpt_div.sv =====
// pipelined restoring divider, two numerators over one shared divisor, one bit per stage
module bpt_div #(
    parameter int NUM_W = 78,
    parameter int DEN_W = 49
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [NUM_W-1:0]    num_a,
    input  logic [NUM_W-1:0]    num_b,
    input  logic [DEN_W-1:0]    den,
    input  bpt_pkg::div_tag_t   in_tag,
    output logic                out_valid,
    output logic [NUM_W-1:0]    quo_a,
    output logic [NUM_W-1:0]    quo_b,
    output bpt_pkg::div_tag_t   out_tag
);

    // numerator bits shift out at the top while quotient bits enter at the bottom
    logic                      valid_reg [NUM_W];
    logic [NUM_W-1:0]          nq_a_reg  [NUM_W];
    logic [NUM_W-1:0]          nq_b_reg  [NUM_W];
    logic [DEN_W-1:0]          rem_a_reg [NUM_W];
    logic [DEN_W-1:0]          rem_b_reg [NUM_W];
    logic [DEN_W-1:0]          den_reg   [NUM_W];
    bpt_pkg::div_tag_t         tag_reg   [NUM_W];

    genvar g;
    generate
        for (g = 0; g < NUM_W; g++)
        begin : g_stage
            logic              src_valid;
            logic [NUM_W-1:0]  src_nq_a;
            logic [NUM_W-1:0]  src_nq_b;
            logic [DEN_W-1:0]  src_rem_a;
            logic [DEN_W-1:0]  src_rem_b;
            logic [DEN_W-1:0]  src_den;
            bpt_pkg::div_tag_t src_tag;
            logic [DEN_W:0]    trial_a;
            logic [DEN_W:0]    trial_b;
            logic              take_a;
            logic              take_b;

            if (g == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_nq_a  = num_a;
                assign src_nq_b  = num_b;
                assign src_rem_a = '0;
                assign src_rem_b = '0;
                assign src_den   = den;
                assign src_tag   = in_tag;
            end
            else
            begin : g_next
                assign src_valid = valid_reg[g-1];
                assign src_nq_a  = nq_a_reg[g-1];
                assign src_nq_b  = nq_b_reg[g-1];
                assign src_rem_a = rem_a_reg[g-1];
                assign src_rem_b = rem_b_reg[g-1];
                assign src_den   = den_reg[g-1];
                assign src_tag   = tag_reg[g-1];
            end

            always_comb
            begin
                trial_a = {src_rem_a, src_nq_a[NUM_W-1]};
                trial_b = {src_rem_b, src_nq_b[NUM_W-1]};
                take_a  = trial_a >= {1'b0, src_den};
                take_b  = trial_b >= {1'b0, src_den};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else
                begin
                    valid_reg[g] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                nq_a_reg[g]  <= {src_nq_a[NUM_W-2:0], take_a};
                nq_b_reg[g]  <= {src_nq_b[NUM_W-2:0], take_b};
                rem_a_reg[g] <= take_a ? DEN_W'(trial_a - {1'b0, src_den})
                                       : trial_a[DEN_W-1:0];
                rem_b_reg[g] <= take_b ? DEN_W'(trial_b - {1'b0, src_den})
                                       : trial_b[DEN_W-1:0];
                den_reg[g]   <= src_den;
                tag_reg[g]   <= src_tag;
            end
        end
    endgenerate

    assign out_valid = valid_reg[NUM_W-1];
    assign quo_a     = nq_a_reg[NUM_W-1];
    assign quo_b     = nq_b_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];

endmodule

// ===== src/barycentric_point_in_triangle.sv =====
// top level of the pipelined barycentric point-in-triangle test
//
// A request is three vertices and a query point in signed fixed point, taken
// at a rising edge with start high and busy low. busy is always low: the
// pipeline takes a new request every cycle, one request per cycle sustained.
// Each request gives one result: weights u, v, w (saturated Q3.28),
// inside_res and degenerate, shown for one cycle with done high.
// A request passes through input differences, products, cross terms,
// magnitudes and signs, then the restoring divider, which resolves one
// quotient bit per stage, and then signing and the final test.
// Results leave in request order and the receiver cannot hold them off.
// tolerance is written with tolerance_we and tolerance_data; the user must
// write it only while no request is in flight, and the block itself does
// not enforce this. Reset clears all valid bits and sets tolerance to zero;
// the first request can be given in the cycle after reset is released.
module barycentric_point_in_triangle #(
    parameter int COORD_WIDTH = 24,
    parameter int COORD_FRAC  = 16,
    parameter int WEIGHT_FRAC = 28
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tolerance_we,
    input  logic [bpt_pkg::TOL_W-1:0]      tolerance_data,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  first_x,
    input  logic signed [COORD_WIDTH-1:0]  first_y,
    input  logic signed [COORD_WIDTH-1:0]  second_x,
    input  logic signed [COORD_WIDTH-1:0]  second_y,
    input  logic signed [COORD_WIDTH-1:0]  third_x,
    input  logic signed [COORD_WIDTH-1:0]  third_y,
    input  logic signed [COORD_WIDTH-1:0]  query_x,
    input  logic signed [COORD_WIDTH-1:0]  query_y,
    output logic                           done,
    output logic signed [bpt_pkg::OUT_W-1:0] weight_u,
    output logic signed [bpt_pkg::OUT_W-1:0] weight_v,
    output logic signed [bpt_pkg::OUT_W-1:0] weight_w,
    output logic                           inside_res,
    output logic                           degenerate
);

    localparam int DW    = COORD_WIDTH + 1;    // edge difference
    localparam int PW    = 2 * DW;             // product and cross term
    localparam int MW    = PW - 1;             // cross term magnitude
    localparam int NUM_W = MW + WEIGHT_FRAC;   // scaled numerator, quotient
    localparam int QW    = NUM_W + 1;          // signed quotient
    localparam int EW    = QW + 2;             // room for u + v and w
    localparam int LAT   = NUM_W + 6;
    localparam int OW    = bpt_pkg::OUT_W;

    // the coordinate scale cancels in every ratio
    localparam int FRAC_UNUSED = COORD_FRAC;

    logic [bpt_pkg::TOL_W-1:0] tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= '0;
        end
        else if (tolerance_we)
        begin
            tolerance_reg <= tolerance_data;
        end
    end

    assign busy = 1'b0;

    // stage 1: edge vectors from the first vertex
    logic                 v1_reg;
    logic signed [DW-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, dx_reg, dy_reg;

    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] p_d0_reg, p_d1_reg, p_u0_reg, p_u1_reg, p_v0_reg, p_v1_reg;

    // stage 3: cross terms
    logic                 v3_reg;
    logic signed [PW-1:0] den_reg, nu_reg, nv_reg;

    // stage 4: magnitudes and signs
    logic                 v4_reg;
    logic [MW-1:0]        mden_reg, mnu_reg, mnv_reg;
    bpt_pkg::div_tag_t    tag4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1x_reg <= DW'(second_x) - DW'(first_x);
        e1y_reg <= DW'(second_y) - DW'(first_y);
        e0x_reg <= DW'(third_x) - DW'(first_x);
        e0y_reg <= DW'(third_y) - DW'(first_y);
        dx_reg  <= DW'(query_x) - DW'(first_x);
        dy_reg  <= DW'(query_y) - DW'(first_y);

        p_d0_reg <= e0x_reg * e1y_reg;
        p_d1_reg <= e0y_reg * e1x_reg;
        p_u0_reg <= dx_reg * e1y_reg;
        p_u1_reg <= dy_reg * e1x_reg;
        p_v0_reg <= e0x_reg * dy_reg;
        p_v1_reg <= e0y_reg * dx_reg;

        den_reg <= p_d0_reg - p_d1_reg;
        nu_reg  <= p_u0_reg - p_u1_reg;
        nv_reg  <= p_v0_reg - p_v1_reg;

        mden_reg <= den_reg[PW-1] ? MW'(-den_reg) : den_reg[MW-1:0];
        mnu_reg  <= nu_reg[PW-1]  ? MW'(-nu_reg)  : nu_reg[MW-1:0];
        mnv_reg  <= nv_reg[PW-1]  ? MW'(-nv_reg)  : nv_reg[MW-1:0];
        tag4_reg.neg_u <= nu_reg[PW-1] ^ den_reg[PW-1];
        tag4_reg.neg_v <= nv_reg[PW-1] ^ den_reg[PW-1];
        tag4_reg.degen <= (den_reg == '0) && (FRAC_UNUSED >= 0);
    end

    logic              dv_valid;
    logic [NUM_W-1:0]  q_u, q_v;
    bpt_pkg::div_tag_t dv_tag;

    bpt_div #(
        .NUM_W (NUM_W),
        .DEN_W (MW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .num_a     ({mnu_reg, {WEIGHT_FRAC{1'b0}}}),
        .num_b     ({mnv_reg, {WEIGHT_FRAC{1'b0}}}),
        .den       (mden_reg),
        .in_tag    (tag4_reg),
        .out_valid (dv_valid),
        .quo_a     (q_u),
        .quo_b     (q_v),
        .out_tag   (dv_tag)
    );

    // stage 5: signed weights
    logic                 v5_reg;
    logic signed [QW-1:0] u5_reg, v5w_reg;
    logic                 degen5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        u5_reg     <= dv_tag.neg_u ? -$signed({1'b0, q_u}) : $signed({1'b0, q_u});
        v5w_reg    <= dv_tag.neg_v ? -$signed({1'b0, q_v}) : $signed({1'b0, q_v});
        degen5_reg <= dv_tag.degen;
    end

    function automatic logic [OW-1:0] sat_out(input logic signed [EW-1:0] a);
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] lo;
        hi = $signed({{(EW-OW){1'b0}}, bpt_pkg::OUT_MAX});
        lo = $signed({{(EW-OW){1'b1}}, bpt_pkg::OUT_MIN});
        if (a > hi)
            return bpt_pkg::OUT_MAX;
        else if (a < lo)
            return bpt_pkg::OUT_MIN;
        else
            return a[OW-1:0];
    endfunction

    // stage 6: w, inside test, saturation
    logic signed [EW-1:0] ue, ve, sum_uv, one_e, tol_e, we_full;
    logic                 inside_c;

    always_comb
    begin
        ue      = EW'(u5_reg);
        ve      = EW'(v5w_reg);
        sum_uv  = ue + ve;
        one_e   = $signed(EW'(1) << WEIGHT_FRAC);
        tol_e   = $signed({{(EW-bpt_pkg::TOL_W){1'b0}}, tolerance_reg});
        we_full = one_e - sum_uv;
        inside_c = (ue >= -tol_e) && (ve >= -tol_e) && (sum_uv <= one_e + tol_e);
    end

    logic          done_reg;
    logic [OW-1:0] wu_reg, wv_reg, ww_reg;
    logic          inside_reg, degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (degen5_reg)
        begin
            wu_reg     <= '0;
            wv_reg     <= '0;
            ww_reg     <= '0;
            inside_reg <= 1'b0;
            degen_reg  <= 1'b1;
        end
        else
        begin
            wu_reg     <= sat_out(ue);
            wv_reg     <= sat_out(ve);
            ww_reg     <= sat_out(we_full);
            inside_reg <= inside_c;
            degen_reg  <= 1'b0;
        end
    end

    assign done       = done_reg;
    assign weight_u   = $signed(wu_reg);
    assign weight_v   = $signed(wv_reg);
    assign weight_w   = $signed(ww_reg);
    assign inside_res = inside_reg;
    assign degenerate = degen_reg;

    // every accepted request comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("request lost in pipeline");

    // nothing comes out that was not requested
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without request");

    // a degenerate triangle never reports inside and has zero u and w weights
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> !inside_res && weight_u == '0 && weight_w == '0)
        else $error("degenerate result not cleared");

    // inside implies u is well away from negative saturation
    a_inside_u: assert property (@(posedge clk) disable iff (!rst_n)
        done && inside_res |-> !degenerate && weight_u != $signed(bpt_pkg::OUT_MIN))
        else $error("inside with saturated weight");

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the barycentric point-in-triangle test
`timescale 1ns / 100ps

module tb_top;

    localparam int CW = 24;
    localparam int WF = 28;
    localparam int LATENCY = 2 * (CW + 1) - 1 + WF + 6;
    localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
    localparam int N_RANDOM = 1450;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic tolerance_we = 1'b0;
    logic [bpt_pkg::TOL_W-1:0] tolerance_data = '0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
    logic signed [CW-1:0] third_x = '0, third_y = '0, query_x = '0, query_y = '0;
    logic done;
    logic signed [bpt_pkg::OUT_W-1:0] weight_u, weight_v, weight_w;
    logic inside_res, degenerate;

    typedef struct {
        logic signed [CW-1:0] c [8];
    } tri_req_t;

    typedef struct {
        logic [bpt_pkg::OUT_W-1:0] u, v, w;
        logic in_tri;
        logic degen;
    } bary_t;

    // directed row: known expectation only where typed in
    typedef struct {
        tri_req_t req;
        bit       typed;
        bary_t    res;
    } dir_row_t;

    bary_t weights_due [$];
    logic [bpt_pkg::TOL_W-1:0] tol_now = '0;
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    barycentric_point_in_triangle dut (
        .clk(clk), .rst_n(rst_n),
        .tolerance_we(tolerance_we), .tolerance_data(tolerance_data),
        .start(start), .busy(busy),
        .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
        .third_x(third_x), .third_y(third_y), .query_x(query_x), .query_y(query_y),
        .done(done), .weight_u(weight_u), .weight_v(weight_v), .weight_w(weight_w),
        .inside_res(inside_res), .degenerate(degenerate)
    );

    always #5 clk = ~clk;

    function automatic logic [bpt_pkg::OUT_W-1:0] clamp32(logic signed [127:0] a);
        if (a > 128'sd2147483647) return bpt_pkg::OUT_MAX;
        if (a < -128'sd2147483648) return bpt_pkg::OUT_MIN;
        return a[bpt_pkg::OUT_W-1:0];
    endfunction

    // exact quotient scaled by 2^WF, truncated toward zero
    function automatic logic signed [127:0] scaled_quot(logic signed [127:0] n,
                                                        logic signed [127:0] d);
        logic [127:0] mn, md, q;
        logic neg;
        neg = (n < 0) != (d < 0);
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        q = (mn << WF) / md;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic bary_t predict_weights(tri_req_t r, logic [bpt_pkg::TOL_W-1:0] tol);
        logic signed [127:0] e1x, e1y, e0x, e0y, dx, dy, den, u, v, w, one, lo, hi;
        bary_t o;
        e1x = r.c[2] - r.c[0]; e1y = r.c[3] - r.c[1];
        e0x = r.c[4] - r.c[0]; e0y = r.c[5] - r.c[1];
        dx  = r.c[6] - r.c[0]; dy  = r.c[7] - r.c[1];
        den = e0x * e1y - e0y * e1x;
        if (den == 0)
        begin
            o.u = '0; o.v = '0; o.w = '0; o.in_tri = 1'b0; o.degen = 1'b1;
            return o;
        end
        u = scaled_quot(dx * e1y - dy * e1x, den);
        v = scaled_quot(e0x * dy - e0y * dx, den);
        one = 128'sd1 <<< WF;
        w = one - u - v;
        lo = -$signed({118'd0, tol});
        hi = one + $signed({118'd0, tol});
        o.u = clamp32(u); o.v = clamp32(v); o.w = clamp32(w);
        o.in_tri = (u >= lo) && (v >= lo) && (u + v <= hi);
        o.degen = 1'b0;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [bpt_pkg::OUT_W-1:0] got,
                                   logic [bpt_pkg::OUT_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        bary_t e;
        if (rst_n && done)
        begin
            if (weights_due.size() == 0)
                report_mismatch("unexpected result", weight_u, 0);
            else
            begin
                e = weights_due.pop_front();
                if (weight_u !== e.u) report_mismatch("weight_u", weight_u, e.u);
                if (weight_v !== e.v) report_mismatch("weight_v", weight_v, e.v);
                if (weight_w !== e.w) report_mismatch("weight_w", weight_w, e.w);
                if (inside_res !== e.in_tri) report_mismatch("inside_res", inside_res, e.in_tri);
                if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
            end
        end
    end

    // watchdog on cycles with nothing accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(tri_req_t r, bit typed, bary_t want);
        while (!calm && $urandom_range(99) < 34)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        first_x <= r.c[0]; first_y <= r.c[1]; second_x <= r.c[2]; second_y <= r.c[3];
        third_x <= r.c[4]; third_y <= r.c[5]; query_x <= r.c[6]; query_y <= r.c[7];
        @(posedge clk);
        while (busy) @(posedge clk);
        weights_due.push_back(typed ? want : predict_weights(r, tol_now));
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (weights_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [bpt_pkg::TOL_W-1:0] t);
        drain();
        tolerance_we <= 1'b1;
        tolerance_data <= t;
        @(posedge clk);
        tolerance_we <= 1'b0;
        tol_now = t;
    endtask

    function automatic tri_req_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
        tri_req_t r;
        r.c[0] = CW'(a); r.c[1] = CW'(b); r.c[2] = CW'(c); r.c[3] = CW'(d);
        r.c[4] = CW'(e); r.c[5] = CW'(f); r.c[6] = CW'(g); r.c[7] = CW'(h);
        return r;
    endfunction

    // random coordinate with wide spread of magnitudes
    function automatic logic signed [CW-1:0] rnd_coord();
        case ($urandom_range(3))
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(2 * 65536)) - 65536);
            2: return CW'($signed($urandom_range(2048)) - 1024);
            default: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
        endcase
    endfunction

    function automatic tri_req_t rnd_request();
        tri_req_t r;
        int k;
        for (k = 0; k < 8; k++) r.c[k] = rnd_coord();
        k = $urandom_range(9);
        if (k == 0)
        begin
            r.c[2] = r.c[0]; r.c[3] = r.c[1];
        end
        else if (k == 1)
        begin
            // collinear third vertex
            r.c[4] = CW'(r.c[0] + 2 * (r.c[2] - r.c[0]));
            r.c[5] = CW'(r.c[1] + 2 * (r.c[3] - r.c[1]));
        end
        else if (k < 5)
        begin
            // query near the centroid
            r.c[6] = CW'((r.c[0] + r.c[2] + r.c[4]) / 3 + $signed($urandom_range(64)) - 32);
            r.c[7] = CW'((r.c[1] + r.c[3] + r.c[5]) / 3 + $signed($urandom_range(64)) - 32);
        end
        else if (k == 5)
        begin
            // query on a vertex
            r.c[6] = r.c[4]; r.c[7] = r.c[5];
        end
        return r;
    endfunction

    dir_row_t dir_rows [$];
    bary_t degen_res, zero_res;

    initial
    begin
        tri_req_t r;
        int i;
        degen_res = '{u: '0, v: '0, w: '0, in_tri: 1'b0, degen: 1'b1};
        zero_res = degen_res;
        dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, degen_res});
        dir_rows.push_back('{mk(5, 7, 5, 7, 9, 9, 1, 1), 1'b1, degen_res});
        dir_rows.push_back('{mk(0, 0, 65536, 65536, 131072, 131072, 3, 4), 1'b1, degen_res});
        // unit triangle: query at first vertex gives u=v=0, w=1
        dir_rows.push_back('{mk(0, 0, 65536, 0, 0, 65536, 0, 0), 1'b1,
                             '{u: 0, v: 0, w: 32'h1000_0000, in_tri: 1'b1, degen: 1'b0}});
        dir_rows.push_back('{mk(0, 0, 65536, 0, 0, 65536, 0, 65536), 1'b0, zero_res});
        dir_rows.push_back('{mk(0, 0, 65536, 0, 0, 65536, 65536, 0), 1'b0, zero_res});
        dir_rows.push_back('{mk(0, 0, 65536, 0, 0, 65536, 65537, 0), 1'b0, zero_res});
        dir_rows.push_back('{mk(0, 0, 65536, 0, 0, 65536, -1, 0), 1'b0, zero_res});
        dir_rows.push_back('{mk(0, 0, 65536, 0, 0, 65536, 20000, 20000), 1'b0, zero_res});
        // tiny triangle with far query: saturation both ways
        dir_rows.push_back('{mk(0, 0, 1, 0, 0, 1, 8388607, 8388607), 1'b0, zero_res});
        dir_rows.push_back('{mk(0, 0, 1, 0, 0, 1, -8388608, -8388608), 1'b0, zero_res});
        dir_rows.push_back('{mk(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607,
                                8388607, 8388607), 1'b0, zero_res});
        dir_rows.push_back('{mk(8388607, 8388607, -8388608, 8388607, 8388607, -8388608,
                                0, 0), 1'b0, zero_res});
        dir_rows.push_back('{mk(-8388608, 8388607, 8388607, -8388608, 0, 0,
                                -8388608, -8388608), 1'b0, zero_res});
        dir_rows.push_back('{mk(100, -200, -300, 400, 500, 600, 700, -800), 1'b0, zero_res});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_rows.size(); i++)
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        write_tolerance(10'd1023);
        for (i = 4; i < dir_rows.size(); i++)
            send_request(dir_rows[i].req, 1'b0, zero_res);
        write_tolerance(10'd1);
        for (i = 4; i < 9; i++)
            send_request(dir_rows[i].req, 1'b0, zero_res);

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i % 300 == 150)
                write_tolerance(i == 750 ? 10'd0 : 10'($urandom_range(1023)));
            calm = (i >= 400 && i < 600);
            r = rnd_request();
            send_request(r, 1'b0, zero_res);
        end
        start <= 1'b0;

        while (weights_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
